// ===== design/uxe_pkg.sv =====
package uxe_pkg;

  // Sequence and alphabet limits
  localparam int MAX_LEN       = 65536;
  localparam int ALPHABET_SIZE = 32;
  localparam int RES_W         = 5;
  localparam int ADDR_W        = $clog2(ALPHABET_SIZE * ALPHABET_SIZE);
  localparam int STEP_W        = $clog2(MAX_LEN + 1);

  // Field widths
  localparam int SCORE_W = 8;
  localparam int SEED_W  = 16;
  localparam int SUM_W   = 24;
  localparam int POS_W   = 17;
  localparam int DROP_W  = 8;

  // Drop-off after reset
  localparam logic [DROP_W-1:0] DROP_RESET = 8'd22;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_RIGHT  = 2'd1,
    CMD_LEFT   = 2'd2,
    CMD_FINISH = 2'd3
  } cmd_t;

  // One classified request on its way to the extension back end
  typedef struct packed {
    cmd_t                      cmd;
    logic signed [SCORE_W-1:0] score;
    logic [SEED_W-1:0]         seed;
  } item_t;

endpackage

// ===== design/uxe_front.sv =====
module uxe_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  uxe_pkg::cmd_t                 in_cmd,
  input  logic [uxe_pkg::RES_W-1:0]     in_query,
  input  logic [uxe_pkg::RES_W-1:0]     in_subject,
  input  logic [uxe_pkg::SCORE_W-1:0]   in_value,
  input  logic [uxe_pkg::SEED_W-1:0]    in_seed,
  input  logic [uxe_pkg::QCNT_W-1:0]    queue_count,
  output logic                          push,
  output uxe_pkg::item_t                push_item
);

  logic signed [uxe_pkg::SCORE_W-1:0] score_matrix [uxe_pkg::ALPHABET_SIZE*uxe_pkg::ALPHABET_SIZE];

  logic                               accept;
  logic                               in_alpha;
  logic [uxe_pkg::ADDR_W-1:0]         addr;
  logic                               stage_valid;
  uxe_pkg::cmd_t                      stage_cmd;
  logic                               stage_alpha;
  logic [uxe_pkg::SEED_W-1:0]         stage_seed;
  logic signed [uxe_pkg::SCORE_W-1:0] rd_data;

  // Take a request only when the queue has room for everything in flight
  assign in_ready = ({1'b0, queue_count} + {{uxe_pkg::QCNT_W{1'b0}}, stage_valid})
                    < (uxe_pkg::QCNT_W+1)'(uxe_pkg::QUEUE_DEPTH);
  assign accept   = in_valid && in_ready;

  assign in_alpha = (int'(in_query) < uxe_pkg::ALPHABET_SIZE) &&
                    (int'(in_subject) < uxe_pkg::ALPHABET_SIZE);
  assign addr     = uxe_pkg::ADDR_W'(int'(in_query) * uxe_pkg::ALPHABET_SIZE + int'(in_subject));

  // Write matrix entries on load, read the pair score otherwise
  always_ff @(posedge clk) begin
    if (accept) begin
      if (in_cmd == uxe_pkg::CMD_LOAD) begin
        if (in_alpha) begin
          score_matrix[addr] <= in_value;
        end
      end else begin
        rd_data <= score_matrix[addr];
      end
    end
  end

  // Hold the classified request while its score is read
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else begin
      stage_valid <= accept && (in_cmd != uxe_pkg::CMD_LOAD);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage_cmd   <= in_cmd;
      stage_alpha <= in_alpha;
      stage_seed  <= in_seed;
    end
  end

  // Residues outside the alphabet score zero
  assign push            = stage_valid;
  assign push_item.cmd   = stage_cmd;
  assign push_item.score = stage_alpha ? rd_data : '0;
  assign push_item.seed  = stage_seed;

`ifndef SYNTHESIS
  a_push_has_room: assert property (@(posedge clk) disable iff (rst)
    stage_valid |-> (int'(queue_count) < uxe_pkg::QUEUE_DEPTH))
    else $error("front pushed into a full queue");
  a_no_load_in_stage: assert property (@(posedge clk) disable iff (rst)
    stage_valid |-> (stage_cmd != uxe_pkg::CMD_LOAD))
    else $error("matrix load reached the queue");
`endif

endmodule

// ===== design/uxe_queue.sv =====
module uxe_queue (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  uxe_pkg::item_t             push_item,
  input  logic                       pop,
  output logic                       head_valid,
  output uxe_pkg::item_t             head_item,
  output logic [uxe_pkg::QCNT_W-1:0] count
);

  uxe_pkg::item_t              entries [uxe_pkg::QUEUE_DEPTH];
  logic [uxe_pkg::QPTR_W-1:0]  wr_ptr;
  logic [uxe_pkg::QPTR_W-1:0]  rd_ptr;

  assign head_valid = (count != '0);
  assign head_item  = entries[rd_ptr];

  // Store pushed requests
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_pop_not_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> (count != '0))
    else $error("queue popped while empty");
`endif

endmodule

// ===== design/uxe_back.sv =====
module uxe_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [uxe_pkg::DROP_W-1:0]  cfg_data,
  input  logic                        head_valid,
  input  uxe_pkg::item_t              head_item,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [uxe_pkg::SUM_W-1:0] out_best,
  output logic [uxe_pkg::POS_W-1:0]   out_left,
  output logic [uxe_pkg::POS_W-1:0]   out_right
);

  localparam int THR_W = uxe_pkg::SUM_W + 2;
  localparam int PSUM_W = uxe_pkg::POS_W + 1;

  logic [uxe_pkg::DROP_W-1:0]         drop_off;
  logic signed [uxe_pkg::SUM_W-1:0]   running_sum, running_sum_next;
  logic signed [uxe_pkg::SUM_W-1:0]   best_sum, best_sum_next;
  logic [uxe_pkg::POS_W-1:0]          best_right_offset, best_right_offset_next;
  logic signed [uxe_pkg::POS_W-1:0]   best_left_offset, best_left_offset_next;
  logic [uxe_pkg::STEP_W-1:0]         step_offset, step_offset_next;
  logic                               phase_stopped, phase_stopped_next;
  logic                               left_started, left_started_next;

  logic                               is_left;
  logic [uxe_pkg::STEP_W-1:0]         eff_step;
  logic                               eff_stopped;
  logic signed [uxe_pkg::SUM_W-1:0]   base_sum;
  logic signed [uxe_pkg::SUM_W:0]     wide_sum;
  logic signed [uxe_pkg::SUM_W-1:0]   sat_sum;
  logic signed [THR_W-1:0]            drop_thr;
  logic                               new_best;
  logic                               drop_hit;
  logic                               take_pair;
  logic                               load_out;

  // Right offsets reach MAX_LEN, so the offset comes in one bit wider
  function automatic logic [uxe_pkg::POS_W-1:0] pos_clip(
    input logic [uxe_pkg::SEED_W-1:0] seed,
    input logic signed [PSUM_W-1:0] off
  );
    logic signed [PSUM_W-1:0] p;
    p = $signed({{(PSUM_W-uxe_pkg::SEED_W){1'b0}}, seed}) + off;
    if (p < 0) begin
      return '0;
    end
    return p[uxe_pkg::POS_W-1:0];
  endfunction

  // Drop-off register; the user must write it only while idle, the block itself does not enforce this
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      drop_off <= uxe_pkg::DROP_RESET;
    end else if (cfg_valid) begin
      drop_off <= cfg_data;
    end
  end

  // Pop pairs freely; a finish waits for the output slot
  assign load_out = head_valid && (head_item.cmd == uxe_pkg::CMD_FINISH) &&
                    (!out_valid || out_ready);
  assign pop      = head_valid && ((head_item.cmd != uxe_pkg::CMD_FINISH) || !out_valid ||
                                   out_ready);

  // The first left pair restarts the phase from the best sum
  assign is_left     = (head_item.cmd == uxe_pkg::CMD_LEFT);
  assign eff_step    = (is_left && !left_started) ? '0 : step_offset;
  assign eff_stopped = (is_left && !left_started) ? 1'b0 : phase_stopped;
  assign base_sum    = (is_left && !left_started) ? best_sum : running_sum;

  // Saturating add and the two stop tests
  assign wide_sum = (uxe_pkg::SUM_W+1)'(base_sum) + (uxe_pkg::SUM_W+1)'(head_item.score);
  always_comb begin
    if (wide_sum > (uxe_pkg::SUM_W+1)'(signed'({1'b0, {(uxe_pkg::SUM_W-1){1'b1}}}))) begin
      sat_sum = {1'b0, {(uxe_pkg::SUM_W-1){1'b1}}};
    end else if (wide_sum < (uxe_pkg::SUM_W+1)'(signed'({1'b1, {(uxe_pkg::SUM_W-1){1'b0}}})))
    begin
      sat_sum = {1'b1, {(uxe_pkg::SUM_W-1){1'b0}}};
    end else begin
      sat_sum = wide_sum[uxe_pkg::SUM_W-1:0];
    end
  end
  assign drop_thr = THR_W'(best_sum) - $signed({{(THR_W-uxe_pkg::DROP_W){1'b0}}, drop_off});
  assign new_best = sat_sum > best_sum;
  assign drop_hit = (THR_W'(sat_sum) <= drop_thr) || sat_sum[uxe_pkg::SUM_W-1];

  always_comb begin
    case (head_item.cmd)
      uxe_pkg::CMD_RIGHT: take_pair = !left_started && !phase_stopped &&
                                      (int'(step_offset) < uxe_pkg::MAX_LEN);
      uxe_pkg::CMD_LEFT:  take_pair = !eff_stopped && (int'(eff_step) < uxe_pkg::MAX_LEN);
      default:            take_pair = 1'b0;
    endcase
  end

  // Next extension state
  always_comb begin
    running_sum_next       = running_sum;
    best_sum_next          = best_sum;
    best_right_offset_next = best_right_offset;
    best_left_offset_next  = best_left_offset;
    step_offset_next       = step_offset;
    phase_stopped_next     = phase_stopped;
    left_started_next      = left_started;
    if (pop) begin
      case (head_item.cmd)
        uxe_pkg::CMD_RIGHT: begin
          if (take_pair) begin
            step_offset_next = step_offset + 1'b1;
            if (step_offset == '0) begin
              running_sum_next       = uxe_pkg::SUM_W'(head_item.score);
              best_sum_next          = uxe_pkg::SUM_W'(head_item.score);
              best_right_offset_next = uxe_pkg::POS_W'(1);
            end else begin
              running_sum_next = sat_sum;
              if (new_best) begin
                best_sum_next          = sat_sum;
                best_right_offset_next = uxe_pkg::POS_W'(step_offset + 1'b1);
              end else if (drop_hit) begin
                phase_stopped_next = 1'b1;
              end
            end
          end
        end
        uxe_pkg::CMD_LEFT: begin
          left_started_next  = 1'b1;
          phase_stopped_next = eff_stopped;
          step_offset_next   = eff_step;
          running_sum_next   = base_sum;
          if (take_pair) begin
            step_offset_next = eff_step + 1'b1;
            running_sum_next = sat_sum;
            if (new_best) begin
              best_sum_next         = sat_sum;
              best_left_offset_next = uxe_pkg::POS_W'(-$signed({1'b0, eff_step}));
            end else if (drop_hit) begin
              phase_stopped_next = 1'b1;
            end
          end
        end
        uxe_pkg::CMD_FINISH: begin
          running_sum_next       = '0;
          best_sum_next          = '0;
          best_right_offset_next = uxe_pkg::POS_W'(1);
          best_left_offset_next  = uxe_pkg::POS_W'(1);
          step_offset_next       = '0;
          phase_stopped_next     = 1'b0;
          left_started_next      = 1'b0;
        end
        default: begin
          running_sum_next = running_sum;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum       <= '0;
      best_sum          <= '0;
      best_right_offset <= uxe_pkg::POS_W'(1);
      best_left_offset  <= uxe_pkg::POS_W'(1);
      step_offset       <= '0;
      phase_stopped     <= 1'b0;
      left_started      <= 1'b0;
    end else begin
      running_sum       <= running_sum_next;
      best_sum          <= best_sum_next;
      best_right_offset <= best_right_offset_next;
      best_left_offset  <= best_left_offset_next;
      step_offset       <= step_offset_next;
      phase_stopped     <= phase_stopped_next;
      left_started      <= left_started_next;
    end
  end

  // Output register: load on finish, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_best  <= best_sum;
      out_left  <= pos_clip(head_item.seed, PSUM_W'(best_left_offset));
      out_right <= pos_clip(head_item.seed, $signed({1'b0, best_right_offset}));
    end
  end

`ifndef SYNTHESIS
  a_sum_below_best: assert property (@(posedge clk) disable iff (rst)
    running_sum <= best_sum)
    else $error("running sum exceeds best sum");
  a_left_start_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(left_started) |-> $past(pop && (head_item.cmd == uxe_pkg::CMD_LEFT)))
    else $error("left phase began without a left pair");
  a_finish_clears: assert property (@(posedge clk) disable iff (rst)
    load_out |=> (best_sum == '0) && !left_started && (step_offset == '0))
    else $error("finish did not clear the extension");
`endif

endmodule

// ===== design/ungapped_xdrop_extension_unit.sv =====
// Ungapped X-drop extension scorer: matrix loads, right and left pairs, finish reports.
// A finish is registered with its matrix read in the front stage, written into the queue,
// then taken by the extension update into the output register; later if the queue holds
// older requests. Up to one request per cycle while the queue has room and no finish waits
// on a full output slot, set by the single matrix port and the back end's add/compare.
// Reset (rst, synchronous): drop_off = 22, extension state cleared, queue empty; matrix kept.
module ungapped_xdrop_extension_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // query_residue[4:0], subject_residue[9:5],
                                      // matrix_value[17:10], seed_pos[33:18], zero[39:34]
  input  logic [1:0]  s_axis_tuser,   // command[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // best_score[23:0], left_pos[40:24],
                                      // right_pos[57:41], zero[63:58]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data        // drop_off
);

  logic                                push;
  uxe_pkg::item_t                      push_item;
  logic                                pop;
  logic                                head_valid;
  uxe_pkg::item_t                      head_item;
  logic [uxe_pkg::QCNT_W-1:0]          queue_count;
  logic signed [uxe_pkg::SUM_W-1:0]    out_best;
  logic [uxe_pkg::POS_W-1:0]           out_left;
  logic [uxe_pkg::POS_W-1:0]           out_right;

  // Classify requests and read the matrix
  uxe_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .in_cmd      (uxe_pkg::cmd_t'(s_axis_tuser)),
    .in_query    (s_axis_tdata[4:0]),
    .in_subject  (s_axis_tdata[9:5]),
    .in_value    (s_axis_tdata[17:10]),
    .in_seed     (s_axis_tdata[33:18]),
    .queue_count (queue_count),
    .push        (push),
    .push_item   (push_item)
  );

  // Decouple front and back
  uxe_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item),
    .count      (queue_count)
  );

  // Run the extension and report
  uxe_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_best   (out_best),
    .out_left   (out_left),
    .out_right  (out_right)
  );

  assign m_axis_tdata = {6'b0, out_right, out_left, out_best};

endmodule

// ===== tb/sv/tb_ungapped_xdrop_extension_unit.sv =====
module tb_ungapped_xdrop_extension_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SUM_HI      = 2 ** (uxe_pkg::SUM_W - 1) - 1;
  localparam int SUM_LO      = -(2 ** (uxe_pkg::SUM_W - 1));
  localparam int POS_HI      = 2 ** uxe_pkg::POS_W - 1;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE      = 8;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int TAB_DEPTH   = uxe_pkg::ALPHABET_SIZE * uxe_pkg::ALPHABET_SIZE;

  typedef struct {
    uxe_pkg::cmd_t                      cmd;
    logic [uxe_pkg::RES_W-1:0]          q_res;
    logic [uxe_pkg::RES_W-1:0]          s_res;
    logic signed [uxe_pkg::SCORE_W-1:0] mval;
    logic [uxe_pkg::SEED_W-1:0]         seed;
  } req_t;

  typedef struct {
    logic [uxe_pkg::SUM_W-1:0] best;
    logic [uxe_pkg::POS_W-1:0] left_pos;
    logic [uxe_pkg::POS_W-1:0] right_pos;
  } hit_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;   // query_residue[4:0], subject_residue[9:5],
                                    // matrix_value[17:10], seed_pos[33:18], zero[39:34]
  logic [1:0]  s_axis_tuser = '0;   // command[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;        // best_score[23:0], left_pos[40:24],
                                    // right_pos[57:41], zero[63:58]
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data = '0;       // drop_off

  ungapped_xdrop_extension_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  // Stimulus side
  req_t pending_q[$];
  req_t in_flight;
  bit   tab_loaded [TAB_DEPTH];
  int   queued_cnt = 0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  logic pressure_on = 1'b0;
  int   hold_cnt = 0;

  // Extension predictor state
  logic signed [uxe_pkg::SCORE_W-1:0] score_tab [TAB_DEPTH];
  logic [uxe_pkg::DROP_W-1:0]         drop_setting = uxe_pkg::DROP_RESET;
  int                                 run_sum = 0;
  int                                 best_sum = 0;
  int                                 best_right = 1;
  int                                 best_left = 1;
  int                                 steps = 0;
  bit                                 stopped = 1'b0;
  bit                                 left_on = 1'b0;
  hit_t                               expected_hits[$];

  // Checking
  hit_t want_hit;
  int   err_cnt = 0;
  int   cycle_cnt = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  // Clamp a subject position into the output field range
  function automatic logic [uxe_pkg::POS_W-1:0] clamp_pos(int v);
    if (v < 0) return '0;
    if (v > POS_HI) return uxe_pkg::POS_W'(POS_HI);
    return uxe_pkg::POS_W'(v);
  endfunction

  // Add one pair score; return 1 on a new best, else apply the drop test
  function automatic bit add_score(int sc);
    run_sum = run_sum + sc;
    if (run_sum > SUM_HI) run_sum = SUM_HI;
    if (run_sum < SUM_LO) run_sum = SUM_LO;
    if (run_sum > best_sum) begin
      best_sum = run_sum;
      return 1'b1;
    end
    if (run_sum <= best_sum - int'(drop_setting) || run_sum < 0) stopped = 1'b1;
    return 1'b0;
  endfunction

  function automatic void clear_extension();
    run_sum    = 0;
    best_sum   = 0;
    best_right = 1;
    best_left  = 1;
    steps      = 0;
    stopped    = 1'b0;
    left_on    = 1'b0;
  endfunction

  // Advance the extension by one accepted request, queue the hit on finish
  function automatic void score_extension(req_t r);
    int   sc;
    int   off;
    hit_t h;
    case (r.cmd)
      uxe_pkg::CMD_LOAD: begin
        score_tab[{r.q_res, r.s_res}] = r.mval;
      end
      uxe_pkg::CMD_RIGHT: begin
        if (!left_on && !stopped && steps < uxe_pkg::MAX_LEN) begin
          sc = score_tab[{r.q_res, r.s_res}];
          steps++;
          if (steps == 1) begin
            run_sum    = sc;
            best_sum   = sc;
            best_right = 1;
          end else if (add_score(sc)) begin
            best_right = steps;
          end
        end
      end
      uxe_pkg::CMD_LEFT: begin
        // first left pair restarts from the best sum
        if (!left_on) begin
          left_on = 1'b1;
          stopped = 1'b0;
          steps   = 0;
          run_sum = best_sum;
        end
        if (!stopped && steps < uxe_pkg::MAX_LEN) begin
          sc  = score_tab[{r.q_res, r.s_res}];
          off = -steps;
          steps++;
          if (add_score(sc)) best_left = off;
        end
      end
      default: begin
        h.best      = uxe_pkg::SUM_W'(best_sum);
        h.left_pos  = clamp_pos(int'(r.seed) + best_left);
        h.right_pos = clamp_pos(int'(r.seed) + best_right);
        expected_hits.push_back(h);
        clear_extension();
      end
    endcase
  endfunction

  task automatic note_mismatch(string msg);
    $display("%0t ns: mismatch: %s", $realtime, msg);
    err_cnt++;
  endtask

  function automatic logic signed [uxe_pkg::SCORE_W-1:0] pick_score();
    if ($urandom_range(9) < 8) return uxe_pkg::SCORE_W'(int'($urandom_range(24)) - 10);
    return uxe_pkg::SCORE_W'($urandom);
  endfunction

  // Mostly a small hot set of residues so extensions run deep
  function automatic logic [uxe_pkg::RES_W-1:0] pick_res();
    int k;
    if ($urandom_range(9) < 7) begin
      k = $urandom_range(7);
      return (k < 4) ? uxe_pkg::RES_W'(k) : uxe_pkg::RES_W'(k + 24);
    end
    return uxe_pkg::RES_W'($urandom_range(uxe_pkg::ALPHABET_SIZE - 1));
  endfunction

  task automatic queue_req(uxe_pkg::cmd_t c, logic [uxe_pkg::RES_W-1:0] qr,
                           logic [uxe_pkg::RES_W-1:0] sr,
                           logic signed [uxe_pkg::SCORE_W-1:0] mv,
                           logic [uxe_pkg::SEED_W-1:0] sd);
    req_t r;
    r.cmd   = c;
    r.q_res = qr;
    r.s_res = sr;
    r.mval  = mv;
    r.seed  = sd;
    pending_q.push_back(r);
    queued_cnt++;
  endtask

  task automatic queue_load(logic [uxe_pkg::RES_W-1:0] qr, logic [uxe_pkg::RES_W-1:0] sr,
                            logic signed [uxe_pkg::SCORE_W-1:0] mv);
    tab_loaded[{qr, sr}] = 1'b1;
    queue_req(uxe_pkg::CMD_LOAD, qr, sr, mv, uxe_pkg::SEED_W'($urandom));
  endtask

  // Load the matrix entry first if it was never written
  task automatic queue_pair(uxe_pkg::cmd_t c, logic [uxe_pkg::RES_W-1:0] qr,
                            logic [uxe_pkg::RES_W-1:0] sr);
    if (!tab_loaded[{qr, sr}]) queue_load(qr, sr, pick_score());
    queue_req(c, qr, sr, uxe_pkg::SCORE_W'($urandom), uxe_pkg::SEED_W'($urandom));
  endtask

  task automatic queue_finish(logic [uxe_pkg::SEED_W-1:0] sd);
    queue_req(uxe_pkg::CMD_FINISH, uxe_pkg::RES_W'($urandom), uxe_pkg::RES_W'($urandom),
              uxe_pkg::SCORE_W'($urandom), sd);
  endtask

  function automatic logic [uxe_pkg::SEED_W-1:0] pick_seed();
    case ($urandom_range(9))
      0:       return uxe_pkg::SEED_W'($urandom_range(3));
      1:       return uxe_pkg::SEED_W'(65535 - $urandom_range(3));
      default: return uxe_pkg::SEED_W'($urandom);
    endcase
  endfunction

  // Mostly well-formed extensions, some noise and broken ordering
  task automatic random_traffic(int n_items);
    int            start;
    int            n_r;
    int            n_l;
    uxe_pkg::cmd_t c;
    start = queued_cnt;
    while (queued_cnt - start < n_items) begin
      if ($urandom_range(99) < 15) begin
        case ($urandom_range(2))
          0:       queue_load(uxe_pkg::RES_W'($urandom), uxe_pkg::RES_W'($urandom),
                              uxe_pkg::SCORE_W'($urandom));
          1:       queue_pair($urandom_range(1) ? uxe_pkg::CMD_RIGHT : uxe_pkg::CMD_LEFT,
                              uxe_pkg::RES_W'($urandom), uxe_pkg::RES_W'($urandom));
          default: queue_finish(pick_seed());
        endcase
      end else begin
        n_r = ($urandom_range(3) == 0) ? $urandom_range(40) : $urandom_range(8);
        n_l = ($urandom_range(3) == 0) ? $urandom_range(40) : $urandom_range(8);
        for (int i = 0; i < n_r + n_l; i++) begin
          c = (i < n_r) ? uxe_pkg::CMD_RIGHT : uxe_pkg::CMD_LEFT;
          if ($urandom_range(99) < 8)
            c = (c == uxe_pkg::CMD_RIGHT) ? uxe_pkg::CMD_LEFT : uxe_pkg::CMD_RIGHT;
          queue_pair(c, pick_res(), pick_res());
        end
        queue_finish(pick_seed());
      end
    end
  endtask

  // Wait until every request is taken and every hit has come back
  task automatic wait_idle();
    while (pending_q.size() != 0 || s_axis_tvalid || expected_hits.size() != 0)
      @(negedge clk);
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_drop(logic [uxe_pkg::DROP_W-1:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    drop_setting = v;
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_idling(int send_pct, int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  // Sender: predict on each accepted request, then offer the next one
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) score_extension(in_flight);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_flight = pending_q.pop_front();
          s_axis_tdata  <= {6'b0, in_flight.seed, in_flight.mval,
                            in_flight.s_res, in_flight.q_res};
          s_axis_tuser  <= in_flight.cmd;
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Count the long receiver hold-off
  always @(posedge clk) begin
    if (rst) begin
      hold_cnt <= 0;
    end else if (pressure_on && hold_cnt < HOLD_CYCLES) begin
      hold_cnt <= hold_cnt + 1;
    end
  end

  // Receiver: check each accepted hit against the oldest expectation
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_hits.size() == 0) begin
          note_mismatch($sformatf("unexpected result %h", m_axis_tdata));
        end else begin
          want_hit = expected_hits.pop_front();
          if (m_axis_tdata[23:0] !== want_hit.best)
            note_mismatch($sformatf("best_score %h, want %h",
                                    m_axis_tdata[23:0], want_hit.best));
          if (m_axis_tdata[40:24] !== want_hit.left_pos)
            note_mismatch($sformatf("left_pos %0d, want %0d",
                                    m_axis_tdata[40:24], want_hit.left_pos));
          if (m_axis_tdata[57:41] !== want_hit.right_pos)
            note_mismatch($sformatf("right_pos %0d, want %0d",
                                    m_axis_tdata[57:41], want_hit.right_pos));
        end
      end
      if (pressure_on && hold_cnt < HOLD_CYCLES)
        m_axis_tready <= 1'b0;
      else
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb_ungapped_xdrop_extension_unit: FAIL");
      $finish;
    end
  end

  initial begin
    // directed: loads at both score extremes, then the corner extensions
    queue_load(5'd0, 5'd0, 8'sd127);
    queue_load(5'd31, 5'd31, -8'sd128);
    queue_load(5'd1, 5'd2, 8'sd5);
    queue_load(5'd2, 5'd1, -8'sd3);
    // finish with no pairs at all
    queue_finish(16'd0);
    // right gain then drop stop, ignored pair, left restart and stop
    repeat (3) queue_pair(uxe_pkg::CMD_RIGHT, 5'd0, 5'd0);
    queue_pair(uxe_pkg::CMD_RIGHT, 5'd31, 5'd31);
    queue_pair(uxe_pkg::CMD_RIGHT, 5'd0, 5'd0);
    queue_pair(uxe_pkg::CMD_LEFT, 5'd0, 5'd0);
    queue_pair(uxe_pkg::CMD_LEFT, 5'd31, 5'd31);
    queue_pair(uxe_pkg::CMD_LEFT, 5'd0, 5'd0);
    queue_finish(16'hFFFF);
    // negative first right pair, below-zero stop, right pair after left began
    queue_pair(uxe_pkg::CMD_RIGHT, 5'd31, 5'd31);
    queue_pair(uxe_pkg::CMD_RIGHT, 5'd31, 5'd31);
    queue_pair(uxe_pkg::CMD_LEFT, 5'd1, 5'd2);
    queue_pair(uxe_pkg::CMD_RIGHT, 5'd0, 5'd0);
    queue_finish(16'd100);
    // left-only gain past the seed, left position clamps at zero
    queue_pair(uxe_pkg::CMD_LEFT, 5'd1, 5'd2);
    queue_pair(uxe_pkg::CMD_LEFT, 5'd1, 5'd2);
    queue_pair(uxe_pkg::CMD_LEFT, 5'd2, 5'd1);
    queue_finish(16'd0);

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    wait_idle();

    // widest drop-off, no idling
    write_drop(8'd255);
    random_traffic(150);
    wait_idle();

    write_drop(8'd0);
    set_idling(62, 0);
    random_traffic(250);
    wait_idle();

    write_drop(uxe_pkg::DROP_W'($urandom_range(1, 254)));
    set_idling(0, 62);
    random_traffic(250);
    wait_idle();

    write_drop(8'd255);
    set_idling(17, 17);
    random_traffic(250);
    wait_idle();

    // hold the receiver off while finishes keep coming, so the input stalls
    write_drop(uxe_pkg::DROP_W'($urandom_range(1, 40)));
    set_idling(0, 0);
    @(posedge clk);
    pressure_on <= 1'b1;
    @(negedge clk);
    repeat (30) begin
      queue_pair(uxe_pkg::CMD_RIGHT, pick_res(), pick_res());
      queue_finish(pick_seed());
    end
    wait_idle();
    @(posedge clk);
    pressure_on <= 1'b0;
    @(negedge clk);

    write_drop(uxe_pkg::DROP_RESET);
    set_idling(17, 17);
    random_traffic(250);
    wait_idle();

    repeat (20) @(posedge clk);
    if (err_cnt == 0 && expected_hits.size() == 0)
      $display("tb_ungapped_xdrop_extension_unit: PASS");
    else
      $display("tb_ungapped_xdrop_extension_unit: FAIL");
    $finish;
  end

endmodule
